>>> rtl/core/mpm_pkg.sv
package mpm_pkg;

  localparam int unsigned ALPHA      = 26;
  localparam int unsigned NODES      = 256;
  localparam int unsigned NODE_W     = 8;
  localparam int unsigned GOTO_DEPTH = NODES * ALPHA;
  localparam int unsigned GADDR_W    = $clog2(GOTO_DEPTH);
  localparam int unsigned SYM_W      = 5;
  localparam int unsigned CNT_W      = 8;

  typedef enum logic [2:0] {
    KIND_PSYM    = 3'd0,
    KIND_PEND    = 3'd1,
    KIND_BUILD   = 3'd2,
    KIND_TEXT    = 3'd3,
    KIND_RESTART = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_BUILT = 2'd2
  } status_e;

  typedef enum logic [15:0] {
    S_CLEAR = 16'h0001,
    S_IDLE  = 16'h0002,
    S_PCHK  = 16'h0004,
    S_EWR   = 16'h0008,
    S_TGO   = 16'h0010,
    S_TWALK = 16'h0020,
    S_B0RD  = 16'h0040,
    S_B0CK  = 16'h0080,
    S_BQRD  = 16'h0100,
    S_BU    = 16'h0200,
    S_BFP   = 16'h0400,
    S_BRV   = 16'h0800,
    S_BRF   = 16'h1000,
    S_BF    = 16'h2000,
    S_BL    = 16'h4000,
    S_RESP  = 16'h8000
  } state_e;

  // base address of a node's row in the goto table
  function automatic logic [GADDR_W-1:0] row_base(input logic [NODE_W-1:0] n);
    row_base = GADDR_W'(n) * GADDR_W'(ALPHA);
  endfunction

endpackage

>>> rtl/core/multi_pattern_matcher.sv
// Restart, unused kinds, repeated build and inserts refused as built or out of range go to
// S_RESP directly; other pattern symbols and ends pass S_PCHK or S_EWR; a text symbol passes
// S_TGO and walks the output chain in S_TWALK. Next accept once the result is registered; a
// stalled output holds S_RESP. Build reads each root letter, then pops each queued node, reads
// its fail link and per letter both rows, writing a link per child. Reset: asynchronous; then
// a clearing pass zeroes the goto, link and count memories with s_axis_tready low.
module multi_pattern_matcher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [4:0] symbol
  input  logic [2:0]  s_axis_tuser,   // [2:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // [1:0] status, [9:2] node_id,
                                      // [25:10] matches_here, [57:26] total_matches
);

  localparam int unsigned NW = mpm_pkg::NODE_W;
  localparam int unsigned GW = mpm_pkg::GADDR_W;

  // memories
  logic [NW-1:0]              gmem [mpm_pkg::GOTO_DEPTH];
  logic [2*NW-1:0]            lmem [mpm_pkg::NODES];   // {fail, output link}
  logic [mpm_pkg::CNT_W-1:0]  cmem [mpm_pkg::NODES];
  logic [NW-1:0]              qmem [mpm_pkg::NODES];

  logic                       g_we, l_we, c_we, q_we;
  logic [GW-1:0]              g_waddr, g_raddr;
  logic [NW-1:0]              g_wdata, g_rdata;
  logic [NW-1:0]              l_waddr, l_raddr, c_waddr, c_raddr, q_waddr, q_raddr;
  logic [2*NW-1:0]            l_wdata, l_rdata;
  logic [mpm_pkg::CNT_W-1:0]  c_wdata, c_rdata;
  logic [NW-1:0]              q_wdata, q_rdata;

  always_ff @(posedge clk_i) begin
    if (g_we) gmem[g_waddr] <= g_wdata;
    g_rdata <= gmem[g_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (l_we) lmem[l_waddr] <= l_wdata;
    l_rdata <= lmem[l_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (c_we) cmem[c_waddr] <= c_wdata;
    c_rdata <= cmem[c_raddr];
  end
  always_ff @(posedge clk_i) begin
    if (q_we) qmem[q_waddr] <= q_wdata;
    q_rdata <= qmem[q_raddr];
  end

  mpm_pkg::state_e state_q, state_d;
  logic [GW-1:0]   clr_q, clr_d, addr_q, addr_d;
  logic [8:0]      used_q, used_d, head_q, head_d, tail_q, tail_d;
  logic [NW-1:0]   cur_q, cur_d, scan_q, scan_d;
  logic [NW-1:0]   u_q, u_d, fp_q, fp_d, v_q, v_d, fv_q, fv_d;
  logic [4:0]      c_q, c_d;
  logic [4:0]      sym_q, sym_d;
  logic [31:0]     total_q, total_d;
  logic            built_q, built_d;
  logic [1:0]      st_q, st_d;
  logic [NW-1:0]   node_q, node_d;
  logic [15:0]     here_q, here_d, sum_q, sum_d;
  logic            ovalid_q, ovalid_d;
  logic [57:0]     odata_q, odata_d;

  logic [4:0]      in_sym, sym_ok;
  logic [2:0]      in_kind;
  logic [16:0]     walk_sum;
  logic [32:0]     tot_sum;
  logic            last_c;

  assign in_sym  = s_axis_tdata[4:0];
  assign in_kind = s_axis_tuser;
  assign sym_ok  = (in_sym < 5'(mpm_pkg::ALPHA)) ? in_sym : 5'd0;
  assign s_axis_tready = (state_q == mpm_pkg::S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {6'd0, odata_q};
  assign walk_sum = {1'b0, sum_q} + 17'(c_rdata);
  assign last_c   = (c_q == 5'(mpm_pkg::ALPHA - 1));

  always_comb begin
    state_d = state_q;
    clr_d = clr_q; addr_d = addr_q; used_d = used_q; head_d = head_q; tail_d = tail_q;
    cur_d = cur_q; scan_d = scan_q; u_d = u_q; fp_d = fp_q; v_d = v_q; fv_d = fv_q;
    c_d = c_q; sym_d = sym_q; total_d = total_q; built_d = built_q;
    st_d = st_q; node_d = node_q; here_d = here_q; sum_d = sum_q;
    ovalid_d = ovalid_q; odata_d = odata_q;
    g_we = 1'b0; g_waddr = addr_q; g_wdata = '0; g_raddr = '0;
    l_we = 1'b0; l_waddr = '0; l_wdata = '0; l_raddr = '0;
    c_we = 1'b0; c_waddr = cur_q; c_wdata = '0; c_raddr = cur_q;
    q_we = 1'b0; q_waddr = tail_q[NW-1:0]; q_wdata = v_q; q_raddr = head_q[NW-1:0];
    tot_sum = '0;

    if (ovalid_q && m_axis_tready) ovalid_d = 1'b0;

    unique case (state_q)
      mpm_pkg::S_CLEAR: begin
        g_we = 1'b1; g_waddr = clr_q;
        if (clr_q < GW'(mpm_pkg::NODES)) begin
          l_we = 1'b1; l_waddr = clr_q[NW-1:0];
          c_we = 1'b1; c_waddr = clr_q[NW-1:0];
        end
        clr_d = clr_q + 1'b1;
        if (clr_q == GW'(mpm_pkg::GOTO_DEPTH - 1)) state_d = mpm_pkg::S_IDLE;
      end
      mpm_pkg::S_IDLE: begin
        g_raddr = mpm_pkg::row_base((in_kind == mpm_pkg::KIND_TEXT) ? scan_q : cur_q)
                  + GW'(sym_ok);
        if (s_axis_tvalid) begin
          sym_d = in_sym; st_d = mpm_pkg::ST_OK; node_d = '0; here_d = '0;
          state_d = mpm_pkg::S_RESP;
          unique case (in_kind)
            mpm_pkg::KIND_PSYM: begin
              node_d = cur_q; addr_d = g_raddr;
              if (built_q) st_d = mpm_pkg::ST_BUILT;
              else if (in_sym < 5'(mpm_pkg::ALPHA)) state_d = mpm_pkg::S_PCHK;
            end
            mpm_pkg::KIND_PEND: begin
              node_d = cur_q;
              if (built_q) st_d = mpm_pkg::ST_BUILT;
              else state_d = mpm_pkg::S_EWR;
            end
            mpm_pkg::KIND_BUILD: begin
              if (!built_q) begin
                c_d = '0; head_d = '0; tail_d = '0; state_d = mpm_pkg::S_B0RD;
              end
            end
            mpm_pkg::KIND_TEXT: state_d = mpm_pkg::S_TGO;
            mpm_pkg::KIND_RESTART: begin
              scan_d = '0; total_d = '0;
            end
            default: ;
          endcase
        end
      end
      mpm_pkg::S_PCHK: begin
        if (g_rdata != '0) begin
          cur_d = g_rdata; node_d = g_rdata;
        end else if (used_q >= 9'(mpm_pkg::NODES)) begin
          st_d = mpm_pkg::ST_FULL;
        end else begin
          g_we = 1'b1; g_waddr = addr_q; g_wdata = used_q[NW-1:0];
          cur_d = used_q[NW-1:0]; node_d = used_q[NW-1:0];
          used_d = used_q + 1'b1;
        end
        state_d = mpm_pkg::S_RESP;
      end
      mpm_pkg::S_EWR: begin
        c_we = 1'b1; c_waddr = cur_q;
        c_wdata = (c_rdata == '1) ? c_rdata : c_rdata + 1'b1;
        cur_d = '0;
        state_d = mpm_pkg::S_RESP;
      end
      mpm_pkg::S_TGO: begin
        v_d = (sym_q < 5'(mpm_pkg::ALPHA)) ? g_rdata : '0;
        scan_d = v_d; node_d = v_d; sum_d = '0;
        l_raddr = v_d; c_raddr = v_d;
        state_d = (v_d == '0) ? mpm_pkg::S_RESP : mpm_pkg::S_TWALK;
      end
      mpm_pkg::S_TWALK: begin
        sum_d = walk_sum[16] ? 16'hFFFF : walk_sum[15:0];
        l_raddr = l_rdata[NW-1:0]; c_raddr = l_rdata[NW-1:0];
        if (l_rdata[NW-1:0] == '0) begin
          here_d = sum_d;
          tot_sum = {1'b0, total_q} + 33'(sum_d);
          total_d = tot_sum[32] ? 32'hFFFF_FFFF : tot_sum[31:0];
          state_d = mpm_pkg::S_RESP;
        end
      end
      mpm_pkg::S_B0RD: begin
        g_raddr = GW'(c_q);
        state_d = mpm_pkg::S_B0CK;
      end
      mpm_pkg::S_B0CK: begin
        if (g_rdata != '0) begin
          q_we = 1'b1; q_waddr = tail_q[NW-1:0]; q_wdata = g_rdata;
          tail_d = tail_q + 1'b1;
        end
        if (last_c) begin
          c_d = '0;
          if (head_q == tail_d) begin
            built_d = 1'b1; state_d = mpm_pkg::S_RESP;
          end else state_d = mpm_pkg::S_BQRD;
        end else begin
          c_d = c_q + 1'b1; state_d = mpm_pkg::S_B0RD;
        end
      end
      mpm_pkg::S_BQRD: begin
        q_raddr = head_q[NW-1:0];
        head_d = head_q + 1'b1;
        state_d = mpm_pkg::S_BU;
      end
      mpm_pkg::S_BU: begin
        u_d = q_rdata; l_raddr = q_rdata;
        state_d = mpm_pkg::S_BFP;
      end
      mpm_pkg::S_BFP: begin
        fp_d = l_rdata[2*NW-1:NW]; c_d = '0;
        state_d = mpm_pkg::S_BRV;
      end
      mpm_pkg::S_BRV: begin
        g_raddr = mpm_pkg::row_base(u_q) + GW'(c_q);
        state_d = mpm_pkg::S_BRF;
      end
      mpm_pkg::S_BRF: begin
        v_d = g_rdata;
        g_raddr = mpm_pkg::row_base(fp_q) + GW'(c_q);
        state_d = mpm_pkg::S_BF;
      end
      mpm_pkg::S_BF: begin
        fv_d = g_rdata;
        if (v_q != '0) begin
          l_raddr = g_rdata; c_raddr = g_rdata;
          state_d = mpm_pkg::S_BL;
        end else begin
          // missing edge takes the fail node's transition
          g_we = 1'b1; g_waddr = mpm_pkg::row_base(u_q) + GW'(c_q); g_wdata = g_rdata;
          state_d = mpm_pkg::S_BRV;
        end
      end
      mpm_pkg::S_BL: begin
        l_we = 1'b1; l_waddr = v_q;
        l_wdata = {fv_q, (c_rdata != '0) ? fv_q : l_rdata[NW-1:0]};
        q_we = 1'b1; q_waddr = tail_q[NW-1:0]; q_wdata = v_q;
        tail_d = tail_q + 1'b1;
        state_d = mpm_pkg::S_BRV;
      end
      mpm_pkg::S_RESP: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          odata_d = {total_q, here_q, node_q, st_q};
          state_d = mpm_pkg::S_IDLE;
        end
      end
      default: state_d = mpm_pkg::S_IDLE;
    endcase

    // letter step shared by both branches of the node pass
    if ((state_q == mpm_pkg::S_BL) ||
        (state_q == mpm_pkg::S_BF && v_q == '0)) begin
      if (last_c) begin
        if (head_q == tail_d) begin
          built_d = 1'b1; state_d = mpm_pkg::S_RESP;
        end else state_d = mpm_pkg::S_BQRD;
      end else c_d = c_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mpm_pkg::S_CLEAR;
      clr_q    <= '0;
      used_q   <= 9'd1;
      head_q   <= '0;
      tail_q   <= '0;
      cur_q    <= '0;
      scan_q   <= '0;
      c_q      <= '0;
      total_q  <= '0;
      built_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      used_q   <= used_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      cur_q    <= cur_d;
      scan_q   <= scan_d;
      c_q      <= c_d;
      total_q  <= total_d;
      built_q  <= built_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    u_q     <= u_d;
    fp_q    <= fp_d;
    v_q     <= v_d;
    fv_q    <= fv_d;
    sym_q   <= sym_d;
    st_q    <= st_d;
    node_q  <= node_d;
    here_q  <= here_d;
    sum_q   <= sum_d;
    odata_q <= odata_d;
  end

endmodule
